### hdl/dcec_pkg.sv
// Shared types and constants for the dual channel encoder calibrator.
// No dependencies; every other file in hdl/ imports this package.
package dcec_pkg;

	localparam int ADC_BITS       = 10;
	localparam int FRACTION_BITS  = 16;
	localparam int LEN_W          = 20;
	localparam logic [LEN_W-1:0] LEN_RESET = 20'd100000;

	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_SAMPLE  = 1'b1;

	typedef logic [ADC_BITS-1:0] dcec_sample_t;

	typedef struct packed {
		logic         command;
		dcec_sample_t sample_a;
		dcec_sample_t sample_b;
	} dcec_in_t;

	typedef struct packed {
		dcec_sample_t min_a;
		dcec_sample_t max_a;
		dcec_sample_t min_b;
		dcec_sample_t max_b;
		dcec_sample_t zero_point_a;
		dcec_sample_t zero_point_b;
		dcec_sample_t half_turn_a;
		dcec_sample_t half_turn_b;
	} dcec_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_A,
		ST_WAIT_A,
		ST_LOAD_B,
		ST_WAIT_B,
		ST_ERR,
		ST_EVAL
	} dcec_state_t;

	typedef enum logic [1:0] {
		PH_TRACK,
		PH_SEARCH,
		PH_DONE
	} dcec_phase_t;

endpackage

### hdl/dcec_divider.sv
// Shared restoring divider: (dividend << FRACTION_BITS) / divisor, one quotient bit per cycle.
// Depends on dcec_pkg for the sample width.
module dcec_divider #(
	parameter int FRACTION_BITS = dcec_pkg::FRACTION_BITS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  dcec_pkg::dcec_sample_t                     dividend,
	input  dcec_pkg::dcec_sample_t                     divisor,
	output logic                                       done,
	output logic [dcec_pkg::ADC_BITS+FRACTION_BITS-1:0] quotient
);
	import dcec_pkg::*;

	localparam int N     = ADC_BITS + FRACTION_BITS;
	localparam int CNT_W = $clog2(N + 1);

	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic [ADC_BITS-1:0] rem_q;
	logic [ADC_BITS-1:0] den_q;
	logic [N-1:0]        quo_q;

	logic [ADC_BITS:0]   trial;
	logic [ADC_BITS:0]   diff;
	logic                fits;
	logic [ADC_BITS-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[N-1]};
		fits     = trial >= {1'b0, den_q};
		diff     = trial - {1'b0, den_q};
		rem_next = fits ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(N);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	// dividend bits shift out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= {dividend, {FRACTION_BITS{1'b0}}};
		end else if (cnt_q != '0) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hdl/dual_channel_encoder_calibrator_core.sv
// Top level of the dual channel encoder calibrator: sequencer, calibration state, result register.
// Depends on dcec_pkg and dcec_divider.
//
// Each accepted item is one sample pair or a restart. A restart, a sample after calibration is
// done, and a tracking sample that does not end phase one are absorbed in idle and leave in_ready
// high. Every other sample runs two divisions in turn on the one shared bit-serial divider, one
// quotient bit a cycle; in_ready stays low until the sequencer is back in idle. The single
// result appears after the last sample of phase two and sits in an output register, so the next
// item can be taken while it waits; a new result stalls only if the old one is unread.
// phase_length is written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module dual_channel_encoder_calibrator_core #(
	parameter int FRACTION_BITS = dcec_pkg::FRACTION_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  dcec_pkg::dcec_in_t       in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output dcec_pkg::dcec_out_t      out_data,
	input  logic                     cfg_wr_en,
	input  logic [dcec_pkg::LEN_W-1:0] cfg_wr_data
);
	import dcec_pkg::*;

	localparam int N     = ADC_BITS + FRACTION_BITS;
	localparam int ERR_W = FRACTION_BITS + 8;
	localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};
	localparam logic [ERR_W:0]   ONE_FIX = (ERR_W+1)'(1) << FRACTION_BITS;

	dcec_state_t state_q, state_nx;
	dcec_phase_t phase_q;

	logic [LEN_W-1:0] phase_len_q;
	logic [LEN_W-1:0] sample_cnt_q;
	dcec_sample_t     min_a_q, max_a_q, min_b_q, max_b_q;
	dcec_sample_t     a_q, b_q;
	dcec_sample_t     bp_a0_q, bp_b0_q, bp_a180_q, bp_b180_q;
	logic [ERR_W-1:0] best0_q, best180_q;
	logic [ERR_W-1:0] qa_q, qb_q, err_q;
	logic             out_valid_q;
	dcec_out_t        out_data_q;

	logic             in_fire;
	logic             phase_ends;
	logic             div_start;
	dcec_sample_t     div_dividend, div_divisor;
	logic             div_done;
	logic [N-1:0]     div_quotient;
	logic [ERR_W-1:0] q_sat;
	logic             range_zero;
	logic [ERR_W:0]   sum;
	logic [ERR_W:0]   err_abs;
	logic             upd0, upd180;
	logic             emit;
	logic             slot_free;
	logic             eval_go;

	dcec_divider #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign in_fire    = in_valid && in_ready;
	assign phase_ends = ({1'b0, sample_cnt_q} + (LEN_W+1)'(1)) >= {1'b0, phase_len_q};

	// divider result, saturated; a channel without range saturates outright
	always_comb begin
		if (state_q == ST_WAIT_A) begin
			range_zero = max_a_q <= min_a_q;
		end else begin
			range_zero = max_b_q <= min_b_q;
		end
		if (range_zero || (|div_quotient[N-1:ERR_W])) begin
			q_sat = ERR_MAX;
		end else begin
			q_sat = div_quotient[ERR_W-1:0];
		end
	end

	always_comb begin
		sum = {1'b0, qa_q} + {1'b0, qb_q};
		if (sum >= ONE_FIX) begin
			err_abs = sum - ONE_FIX;
		end else begin
			err_abs = ONE_FIX - sum;
		end
	end

	assign upd0      = (err_q < best0_q) && (a_q > b_q);
	assign upd180    = (err_q < best180_q) && (a_q < b_q);
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = (state_q == ST_EVAL) && (phase_q == PH_SEARCH) && phase_ends;
	assign eval_go   = (state_q == ST_EVAL) && (!emit || slot_free);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_data.command == CMD_SAMPLE) begin
					if (phase_q == PH_SEARCH || (phase_q == PH_TRACK && phase_ends)) begin
						state_nx = ST_LOAD_A;
					end
				end
			end
			ST_LOAD_A: state_nx = ST_WAIT_A;
			ST_WAIT_A: begin
				if (div_done) begin
					state_nx = ST_LOAD_B;
				end
			end
			ST_LOAD_B: state_nx = ST_WAIT_B;
			ST_WAIT_B: begin
				if (div_done) begin
					state_nx = ST_ERR;
				end
			end
			ST_ERR:  state_nx = ST_EVAL;
			ST_EVAL: begin
				if (eval_go) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = a_q;
		div_divisor  = max_a_q - min_a_q;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_LOAD_A: div_start = 1'b1;
			ST_LOAD_B: begin
				div_start    = 1'b1;
				div_dividend = b_q;
				div_divisor  = max_b_q - min_b_q;
			end
			default: begin
				in_ready  = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_TRACK;
			phase_len_q  <= LEN_RESET;
			sample_cnt_q <= '0;
			min_a_q      <= '1;
			min_b_q      <= '1;
			max_a_q      <= '0;
			max_b_q      <= '0;
			best0_q      <= '0;
			best180_q    <= '0;
			bp_a0_q      <= '0;
			bp_b0_q      <= '0;
			bp_a180_q    <= '0;
			bp_b180_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_wr_en) begin
				phase_len_q <= cfg_wr_data;
			end

			if (in_fire && in_data.command == CMD_RESTART) begin
				phase_q      <= PH_TRACK;
				sample_cnt_q <= '0;
				min_a_q      <= '1;
				min_b_q      <= '1;
				max_a_q      <= '0;
				max_b_q      <= '0;
				best0_q      <= '0;
				best180_q    <= '0;
				bp_a0_q      <= '0;
				bp_b0_q      <= '0;
				bp_a180_q    <= '0;
				bp_b180_q    <= '0;
			end else if (in_fire && phase_q == PH_TRACK) begin
				if (in_data.sample_a < min_a_q) min_a_q <= in_data.sample_a;
				if (in_data.sample_a > max_a_q) max_a_q <= in_data.sample_a;
				if (in_data.sample_b < min_b_q) min_b_q <= in_data.sample_b;
				if (in_data.sample_b > max_b_q) max_b_q <= in_data.sample_b;
				// the final tracking sample finishes in EVAL
				if (!phase_ends) begin
					sample_cnt_q <= sample_cnt_q + 1'b1;
				end
			end

			if (eval_go) begin
				if (phase_q == PH_TRACK) begin
					best0_q      <= err_q;
					best180_q    <= err_q;
					sample_cnt_q <= '0;
					phase_q      <= PH_SEARCH;
				end else begin
					if (upd0) begin
						best0_q <= err_q;
						bp_a0_q <= a_q;
						bp_b0_q <= b_q;
					end
					if (upd180) begin
						best180_q <= err_q;
						bp_a180_q <= a_q;
						bp_b180_q <= b_q;
					end
					if (phase_ends) begin
						sample_cnt_q <= '0;
						phase_q      <= PH_DONE;
					end else begin
						sample_cnt_q <= sample_cnt_q + 1'b1;
					end
				end
			end

			if (eval_go && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_q <= in_data.sample_a;
			b_q <= in_data.sample_b;
		end
		if (state_q == ST_WAIT_A && div_done) begin
			qa_q <= q_sat;
		end
		if (state_q == ST_WAIT_B && div_done) begin
			qb_q <= q_sat;
		end
		if (state_q == ST_ERR) begin
			err_q <= err_abs[ERR_W] ? ERR_MAX : err_abs[ERR_W-1:0];
		end
		if (eval_go && emit) begin
			out_data_q.min_a        <= min_a_q;
			out_data_q.max_a        <= max_a_q;
			out_data_q.min_b        <= min_b_q;
			out_data_q.max_b        <= max_b_q;
			out_data_q.zero_point_a <= upd0 ? a_q : bp_a0_q;
			out_data_q.zero_point_b <= upd0 ? b_q : bp_b0_q;
			out_data_q.half_turn_a  <= upd180 ? a_q : bp_a180_q;
			out_data_q.half_turn_b  <= upd180 ? b_q : bp_b180_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### hdl/dcec_checker.sv
// Port-level checks for the dual channel encoder calibrator, bound to the top level.
// Depends on dcec_pkg and dual_channel_encoder_calibrator_core.
module dcec_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input dcec_pkg::dcec_in_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input dcec_pkg::dcec_out_t out_data
);
	import dcec_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// a restart never produces a result
	a_restart_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.command == CMD_RESTART |=> !$rose(out_valid))
		else $error("result raised right after a restart");

	// a result only follows an evaluation, never straight from idle
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result raised without an evaluation in progress");

	// extremes come from at least one tracked sample
	a_extremes_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.min_a <= out_data.max_a && out_data.min_b <= out_data.max_b)
		else $error("reported minimum exceeds maximum");

endmodule

bind dual_channel_encoder_calibrator_core dcec_checker u_dcec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
